// ===== rtl/core/cpaw_pkg.sv =====
// ----------------------------------------------------------------------------
// cpaw_pkg
// Shared types and constants of the constant-pad address walker.
// ----------------------------------------------------------------------------
package cpaw_pkg;

    localparam int REG_W       = 64;
    localparam int COUNT_W     = 64;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEST_SIZES = 2'd0,
        CFG_PAD_BEFORE = 2'd1,
        CFG_PAD_AFTER  = 2'd2,
        CFG_PAD_WORD   = 2'd3
    } cfg_reg_e;

    // Per-element classification from the coordinate odometer.
    typedef struct packed {
        logic is_padding;
        logic last;
        logic bad;
    } walk_flags_t;

endpackage

// ===== rtl/core/cpaw_odometer.sv =====
// ----------------------------------------------------------------------------
// cpaw_odometer
// Per-dimension coordinate counters with pad classification and carry chain.
// ----------------------------------------------------------------------------
module cpaw_odometer
    import cpaw_pkg::*;
#(
    parameter int DIM_COUNT = 4,
    parameter int DIM_BITS  = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             restart,
    input  logic [REG_W-1:0] dest_sizes,
    input  logic [REG_W-1:0] pad_before,
    input  logic [REG_W-1:0] pad_after,
    output walk_flags_t      flags
);

    logic [DIM_BITS-1:0]  coord_reg  [DIM_COUNT];
    logic [DIM_BITS-1:0]  coord_next [DIM_COUNT];
    logic [DIM_COUNT-1:0] dim_pad;
    logic [DIM_COUNT-1:0] dim_bad;
    logic [DIM_COUNT-1:0] wraps;
    logic [DIM_COUNT:0]   carry;

    // Dimension DIM_COUNT-1 is the innermost and always counts.
    assign carry[DIM_COUNT] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < DIM_COUNT; g++)
        begin : g_dim
            localparam int SHIFT = (DIM_COUNT - 1 - g) * DIM_BITS;

            logic [DIM_BITS-1:0] ext;
            logic [DIM_BITS-1:0] bef;
            logic [DIM_BITS-1:0] aft;
            logic [DIM_BITS-1:0] c;
            logic [DIM_BITS:0]   c_inc;

            assign ext   = dest_sizes[SHIFT +: DIM_BITS];
            assign bef   = pad_before[SHIFT +: DIM_BITS];
            assign aft   = pad_after[SHIFT +: DIM_BITS];
            assign c     = restart ? '0 : coord_reg[g];
            assign c_inc = {1'b0, c} + {{DIM_BITS{1'b0}}, 1'b1};

            assign wraps[g]   = c_inc >= {1'b0, ext};
            assign dim_pad[g] = (c < bef) || (({1'b0, c} + {1'b0, aft}) >= {1'b0, ext});
            assign dim_bad[g] = ({1'b0, bef} + {1'b0, aft}) > {1'b0, ext};
            assign carry[g]   = carry[g+1] & wraps[g];

            always_comb
            begin
                if (!carry[g+1])
                begin
                    coord_next[g] = c;
                end
                else if (wraps[g])
                begin
                    coord_next[g] = '0;
                end
                else
                begin
                    coord_next[g] = c_inc[DIM_BITS-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    coord_reg[g] <= '0;
                end
                else if (advance)
                begin
                    coord_reg[g] <= coord_next[g];
                end
            end
        end
    endgenerate

    // The last element has every coordinate at its final value, so the
    // carry chain also returns all counters to zero after it.
    assign flags.is_padding = |dim_pad;
    assign flags.last       = &wraps;
    assign flags.bad        = |dim_bad;

endmodule

// ===== rtl/core/nd_constant_pad_address_walker.sv =====
// ----------------------------------------------------------------------------
// nd_constant_pad_address_walker
// Walks a padded N-dimensional tensor and emits one address beat per element.
// ----------------------------------------------------------------------------
// Each accepted input beat produces exactly one registered result beat, and
// a new beat is taken in every cycle while the result register is empty or
// being drained, so the sustained rate is one element per cycle. That figure
// is set by the odometer carry chain with its per-dimension compares and the
// 64-bit offset increments, all of which are combinational between the
// coordinate counters and the result register. Configuration registers are
// written through cfg_write/cfg_index/cfg_data and take effect on the next
// accepted beat; the coordinate and offset counters are kept.
module nd_constant_pad_address_walker
    import cpaw_pkg::*;
#(
    parameter int DIM_COUNT = 4,
    parameter int DIM_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]       cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   restart,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   is_padding,
    output logic [REG_W-1:0]       fill_word,
    output logic [COUNT_W-1:0]     source_offset,
    output logic [COUNT_W-1:0]     dest_offset,
    output logic                   last_of_walk,
    output logic                   bad_config
);

    logic [REG_W-1:0]   dest_sizes_reg;
    logic [REG_W-1:0]   pad_before_reg;
    logic [REG_W-1:0]   pad_after_reg;
    logic [REG_W-1:0]   pad_word_reg;

    logic [COUNT_W-1:0] dest_count_reg;
    logic [COUNT_W-1:0] dest_count_next;
    logic [COUNT_W-1:0] source_count_reg;
    logic [COUNT_W-1:0] source_count_next;
    logic [COUNT_W-1:0] dest_base;
    logic [COUNT_W-1:0] source_base;

    logic               out_valid_reg;
    logic               is_padding_reg;
    logic [REG_W-1:0]   fill_word_reg;
    logic [COUNT_W-1:0] source_offset_reg;
    logic [COUNT_W-1:0] dest_offset_reg;
    logic               last_reg;
    logic               bad_reg;

    logic               in_fire;
    walk_flags_t        flags;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_sizes_reg <= '0;
            pad_before_reg <= '0;
            pad_after_reg  <= '0;
            pad_word_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEST_SIZES: dest_sizes_reg <= cfg_data;
                CFG_PAD_BEFORE: pad_before_reg <= cfg_data;
                CFG_PAD_AFTER:  pad_after_reg  <= cfg_data;
                CFG_PAD_WORD:   pad_word_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    cpaw_odometer #(
        .DIM_COUNT (DIM_COUNT),
        .DIM_BITS  (DIM_BITS)
    ) u_odometer (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (in_fire),
        .restart    (restart),
        .dest_sizes (dest_sizes_reg),
        .pad_before (pad_before_reg),
        .pad_after  (pad_after_reg),
        .flags      (flags)
    );

    // Valid elements appear in source row-major order, so the source offset
    // is simply the number of non-padding elements already emitted.
    assign dest_base   = restart ? '0 : dest_count_reg;
    assign source_base = restart ? '0 : source_count_reg;

    always_comb
    begin
        if (flags.last)
        begin
            dest_count_next   = '0;
            source_count_next = '0;
        end
        else
        begin
            dest_count_next   = dest_base + COUNT_W'(1);
            source_count_next = source_base + COUNT_W'(!flags.is_padding);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_count_reg   <= '0;
            source_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                dest_count_reg   <= dest_count_next;
                source_count_reg <= source_count_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            is_padding_reg    <= flags.is_padding;
            fill_word_reg     <= flags.is_padding ? pad_word_reg : '0;
            source_offset_reg <= flags.is_padding ? '0 : source_base;
            dest_offset_reg   <= dest_base;
            last_reg          <= flags.last;
            bad_reg           <= flags.bad;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_padding    = is_padding_reg;
    assign fill_word     = fill_word_reg;
    assign source_offset = source_offset_reg;
    assign dest_offset   = dest_offset_reg;
    assign last_of_walk  = last_reg;
    assign bad_config    = bad_reg;

    a_restart_starts_at_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire && restart |=> out_valid_reg && (dest_offset_reg == '0)
            && (source_offset_reg == '0)
    ) else $error("restart beat did not produce element zero");

    a_padding_has_no_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_padding_reg |-> source_offset_reg == '0
    ) else $error("padding element carries a source offset");

    a_data_has_no_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !is_padding_reg |-> fill_word_reg == '0
    ) else $error("non-padding element carries a fill word");

    a_last_wraps_counts: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire && flags.last |=> (dest_count_reg == '0) && (source_count_reg == '0)
    ) else $error("walk did not wrap after its last element");

endmodule
